// ----- rtl/lbwd_pkg.sv -----
// lbwd_pkg: shared constants for the log burst window detector
// ring sizing, time conversion factors, register indexes and reset values
// no dependencies
`default_nettype none

package lbwd_pkg;

	// ring sizing
	localparam int MAX_THRESHOLD = 1024;
	localparam int PTR_W         = $clog2(MAX_THRESHOLD);
	localparam int CNT_W         = $clog2(MAX_THRESHOLD + 1);
	localparam int TIME_W        = 39;

	// field widths
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int WIN_W    = 24;
	localparam int THR_W    = 11;

	// partial product widths
	localparam int PMON_W  = 26;
	localparam int PDAY_W  = 22;
	localparam int PREST_W = 17;

	// seconds per unit: 365-day years, 30-day months
	localparam logic [TIME_W-1:0]  SECS_YEAR  = TIME_W'(365 * 24 * 60 * 60);
	localparam logic [PMON_W-1:0]  SECS_MONTH = PMON_W'(30 * 24 * 60 * 60);
	localparam logic [PDAY_W-1:0]  SECS_DAY   = PDAY_W'(24 * 60 * 60);
	localparam logic [PREST_W-1:0] SECS_HOUR  = PREST_W'(60 * 60);
	localparam logic [PREST_W-1:0] SECS_MIN   = PREST_W'(60);

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_SECONDS = 1'b0,
		CFG_THRESHOLD      = 1'b1
	} cfg_idx_t;

	// register reset values
	localparam logic [WIN_W-1:0] WINDOW_RESET    = WIN_W'(60);
	localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(1);

endpackage

`default_nettype wire

// ----- rtl/lbwd_ring_ram.sv -----
// lbwd_ring_ram: single write port, single read port ring memory
// read data is registered, read returns old data on collision
// no dependencies
`default_nettype none

module lbwd_ring_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 39,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/log_burst_window_detector_top.sv -----
// log_burst_window_detector_top: sliding window burst detector over timestamped records
// path: a record passes stage 1, stage 2 and the output register before its result is valid
// throughput: one record per cycle, set by one ring read and at most one ring write per record
// the pipeline holds only while a result waits at the output and another is due
// reset clears pointers, counts and report flag, loads register defaults; ring is not cleared
// depends on lbwd_pkg and lbwd_ring_ram
`default_nettype none

module log_burst_window_detector_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lbwd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lbwd_pkg::WIN_W-1:0]        cfg_data,
	// record channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [lbwd_pkg::YEAR_W-1:0]       year,
	input  wire logic [lbwd_pkg::MONTH_W-1:0]      month,
	input  wire logic [lbwd_pkg::DAY_W-1:0]        day,
	input  wire logic [lbwd_pkg::HOUR_W-1:0]       hour,
	input  wire logic [lbwd_pkg::MINUTE_W-1:0]     minute,
	input  wire logic [lbwd_pkg::SECOND_W-1:0]     second_of_minute,
	input  wire logic                              end_of_stream,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   found,
	output logic      [lbwd_pkg::YEAR_W-1:0]       hit_year,
	output logic      [lbwd_pkg::MONTH_W-1:0]      hit_month,
	output logic      [lbwd_pkg::DAY_W-1:0]        hit_day,
	output logic      [lbwd_pkg::HOUR_W-1:0]       hit_hour,
	output logic      [lbwd_pkg::MINUTE_W-1:0]     hit_minute,
	output logic      [lbwd_pkg::SECOND_W-1:0]     hit_second
);

	localparam int PTR_W  = lbwd_pkg::PTR_W;
	localparam int CNT_W  = lbwd_pkg::CNT_W;
	localparam int TIME_W = lbwd_pkg::TIME_W;

	// configuration registers
	logic [lbwd_pkg::WIN_W-1:0] win_q;
	logic [lbwd_pkg::THR_W-1:0] thr_q;

	// front end stream state
	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] seen_q;

	// back end stream state
	logic reported_q;

	// handshake
	logic adv;
	logic in_fire;

	// stage 0 decode
	logic [31:0]      m_w;
	logic [PTR_W-1:0] back;
	logic             s0_always;
	logic             s0_check;
	logic [PTR_W-1:0] rd_addr;

	// stage 1
	logic                               s1_valid_q;
	logic [TIME_W-1:0]                  p_year_s1;
	logic [lbwd_pkg::PMON_W-1:0]        p_mon_s1;
	logic [lbwd_pkg::PDAY_W-1:0]        p_day_s1;
	logic [lbwd_pkg::PREST_W-1:0]       p_rest_s1;
	logic                               always_s1;
	logic                               check_s1;
	logic                               fwd1_s1;
	logic                               fwd2_s1;
	logic [PTR_W-1:0]                   wa_s1;
	logic                               eos_s1;
	logic [lbwd_pkg::YEAR_W-1:0]        yr_s1;
	logic [lbwd_pkg::MONTH_W-1:0]       mo_s1;
	logic [lbwd_pkg::DAY_W-1:0]         dy_s1;
	logic [lbwd_pkg::HOUR_W-1:0]        hr_s1;
	logic [lbwd_pkg::MINUTE_W-1:0]      mi_s1;
	logic [lbwd_pkg::SECOND_W-1:0]      se_s1;
	logic [TIME_W-1:0]                  ram_rd_data;

	// stage 2
	logic                               s2_valid_q;
	logic [TIME_W-1:0]                  t_s2;
	logic [TIME_W-1:0]                  old_s2;
	logic                               always_s2;
	logic                               check_s2;
	logic                               fwd1_s2;
	logic                               fwd2_s2;
	logic [PTR_W-1:0]                   wa_s2;
	logic                               eos_s2;
	logic [lbwd_pkg::YEAR_W-1:0]        yr_s2;
	logic [lbwd_pkg::MONTH_W-1:0]       mo_s2;
	logic [lbwd_pkg::DAY_W-1:0]         dy_s2;
	logic [lbwd_pkg::HOUR_W-1:0]        hr_s2;
	logic [lbwd_pkg::MINUTE_W-1:0]      mi_s2;
	logic [lbwd_pkg::SECOND_W-1:0]      se_s2;

	// last two stored times of the stream, for reads the ring cannot serve yet
	logic [TIME_W-1:0] hist1_q;
	logic [TIME_W-1:0] hist2_q;

	logic [TIME_W-1:0] old_val;
	logic              in_win;
	logic              hit;
	logic              active;
	logic              emits;
	logic              wr_en;
	logic              emit_fire;

	logic out_valid_q;

	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= lbwd_pkg::WINDOW_RESET;
			thr_q <= lbwd_pkg::THRESHOLD_RESET;
		end else if (cfg_valid) begin
			case (lbwd_pkg::cfg_idx_t'(cfg_index))
				lbwd_pkg::CFG_WINDOW_SECONDS: win_q <= cfg_data;
				lbwd_pkg::CFG_THRESHOLD:      thr_q <= cfg_data[lbwd_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// stall only when a result is due while the output still holds one
	assign adv      = !(s2_valid_q && emits && out_valid_q && !out_ready);
	assign in_ready = adv;
	assign in_fire  = in_valid && adv;

	// threshold decode and look-back address
	always_comb begin
		m_w       = (thr_q == '0) ? 32'd1 : 32'(thr_q);
		back      = PTR_W'(m_w - 32'd1);
		s0_always = (m_w == 32'd1);
		s0_check  = !s0_always && (m_w <= 32'(lbwd_pkg::MAX_THRESHOLD))
			&& (32'(seen_q) >= (m_w - 32'd1));
		rd_addr   = wp_q - back;
	end

	// front end pointer and fill count, advanced per beat assuming no hit, cleared by the end of a stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			seen_q <= '0;
		end else if (in_fire) begin
			if (end_of_stream) begin
				wp_q   <= '0;
				seen_q <= '0;
			end else begin
				wp_q <= wp_q + PTR_W'(1);
				if (seen_q < CNT_W'(lbwd_pkg::MAX_THRESHOLD)) begin
					seen_q <= seen_q + CNT_W'(1);
				end
			end
		end
	end

	// time ring
	lbwd_ring_ram #(
		.DEPTH (lbwd_pkg::MAX_THRESHOLD),
		.WIDTH (TIME_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wa_s2),
		.wr_data (t_s2),
		.rd_en   (in_fire),
		.rd_addr (rd_addr),
		.rd_data (ram_rd_data)
	);

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= in_valid;
			s2_valid_q <= s1_valid_q;
		end
	end

	// stage 1 payload: partial products of the time formula
	always_ff @(posedge clk) begin
		if (in_fire) begin
			p_year_s1 <= TIME_W'(year) * lbwd_pkg::SECS_YEAR;
			p_mon_s1  <= lbwd_pkg::PMON_W'(month) * lbwd_pkg::SECS_MONTH;
			p_day_s1  <= lbwd_pkg::PDAY_W'(day) * lbwd_pkg::SECS_DAY;
			p_rest_s1 <= lbwd_pkg::PREST_W'(hour) * lbwd_pkg::SECS_HOUR
				+ lbwd_pkg::PREST_W'(minute) * lbwd_pkg::SECS_MIN
				+ lbwd_pkg::PREST_W'(second_of_minute);
			always_s1 <= s0_always;
			check_s1  <= s0_check;
			fwd1_s1   <= (back == PTR_W'(1));
			fwd2_s1   <= (back == PTR_W'(2));
			wa_s1     <= wp_q;
			eos_s1    <= end_of_stream;
			yr_s1     <= year;
			mo_s1     <= month;
			dy_s1     <= day;
			hr_s1     <= hour;
			mi_s1     <= minute;
			se_s1     <= second_of_minute;
		end
	end

	// stage 2 payload: full time and ring data
	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			t_s2      <= p_year_s1 + TIME_W'(p_mon_s1) + TIME_W'(p_day_s1)
				+ TIME_W'(p_rest_s1);
			old_s2    <= ram_rd_data;
			always_s2 <= always_s1;
			check_s2  <= check_s1;
			fwd1_s2   <= fwd1_s1;
			fwd2_s2   <= fwd2_s1;
			wa_s2     <= wa_s1;
			eos_s2    <= eos_s1;
			yr_s2     <= yr_s1;
			mo_s2     <= mo_s1;
			dy_s2     <= dy_s1;
			hr_s2     <= hr_s1;
			mi_s2     <= mi_s1;
			se_s2     <= se_s1;
		end
	end

	// window test with forwarding of the two newest stored times
	always_comb begin
		if (fwd1_s2) begin
			old_val = hist1_q;
		end else if (fwd2_s2) begin
			old_val = hist2_q;
		end else begin
			old_val = old_s2;
		end
		in_win    = (old_val <= t_s2)
			&& (({1'b0, old_val} + (TIME_W + 1)'(win_q)) >= {1'b0, t_s2});
		hit       = always_s2 || (check_s2 && in_win);
		active    = s2_valid_q && !reported_q;
		emits     = active && (hit || eos_s2);
		wr_en     = adv && active && !hit;
		emit_fire = adv && emits;
	end

	// forwarding history
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist2_q <= hist1_q;
			hist1_q <= t_s2;
		end
	end

	// report flag, cleared by the end of a stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= 1'b0;
		end else if (adv && s2_valid_q) begin
			if (eos_s2) begin
				reported_q <= 1'b0;
			end else if (active && hit) begin
				reported_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			found      <= hit;
			hit_year   <= hit ? yr_s2 : '0;
			hit_month  <= hit ? mo_s2 : '0;
			hit_day    <= hit ? dy_s2 : '0;
			hit_hour   <= hit ? hr_s2 : '0;
			hit_minute <= hit ? mi_s2 : '0;
			hit_second <= hit ? se_s2 : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
